/* rtl/color_key_bounding_box_top_macros.svh */
// Assertion helpers included by the tracking stage (ckbb_track).
`ifndef COLOR_KEY_BOUNDING_BOX_TOP_MACROS_SVH
`define COLOR_KEY_BOUNDING_BOX_TOP_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define CKBB_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define CKBB_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

/* rtl/ckbb_pkg.sv */
package ckbb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COORD_W   = 11;
  localparam int CHAN_W    = 8;
  localparam int ARM_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam int ARM_CAP = 5;
  // Smallest span at which floor(span * 3 / 10) reaches the cap.
  localparam int ARM_SAT = (ARM_CAP * 10 + 2) / 3;

  localparam logic [CHAN_W-1:0] RST_RED   = CHAN_W'(225);
  localparam logic [CHAN_W-1:0] RST_GREEN = CHAN_W'(225);
  localparam logic [CHAN_W-1:0] RST_BLUE  = CHAN_W'(65);
  localparam logic [CHAN_W-1:0] RST_TOL   = CHAN_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_TOL   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] tol;
  } color_ref_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic               last;
  } pix_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               hit;
    logic               last;
  } hit_t;

  typedef struct packed {
    logic               mask;
    logic               done;
    logic               found;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
  } box_t;

  function automatic logic chan_ok(input logic [CHAN_W-1:0] v,
                                   input logic [CHAN_W-1:0] r,
                                   input logic [CHAN_W-1:0] tol);
    logic [CHAN_W:0] hi;
    logic [CHAN_W:0] v_up;
    hi   = {1'b0, r} + {1'b0, tol};
    v_up = {1'b0, v} + {1'b0, tol};
    return ({1'b0, v} <= hi) && (v_up >= {1'b0, r});
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                     input int lim);
    logic [COORD_W-1:0] c;
    c = v;
    if (int'(v) >= lim) begin
      c = COORD_W'(lim - 1);
    end
    return c;
  endfunction

  function automatic logic [ARM_W-1:0] arm_of(input logic [COORD_W-1:0] span);
    logic [ARM_W-1:0] a;
    a = ARM_W'(ARM_CAP);
    if (span < COORD_W'(ARM_SAT)) begin
      case (span[4:0]) inside
        [5'd0:5'd3]:   a = ARM_W'(0);
        [5'd4:5'd6]:   a = ARM_W'(1);
        [5'd7:5'd9]:   a = ARM_W'(2);
        [5'd10:5'd13]: a = ARM_W'(3);
        default:       a = ARM_W'(4);
      endcase
    end
    return a;
  endfunction

endpackage

/* rtl/ckbb_front.sv */
module ckbb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ckbb_pkg::COORD_W-1:0] in_pix_x,
  input  logic [ckbb_pkg::COORD_W-1:0] in_pix_y,
  input  logic [ckbb_pkg::CHAN_W-1:0]  in_blue_val,
  input  logic [ckbb_pkg::CHAN_W-1:0]  in_green_val,
  input  logic [ckbb_pkg::CHAN_W-1:0]  in_red_val,
  input  logic                         in_frame_end,
  input  ckbb_pkg::color_ref_t         refs,
  output logic                         dn_valid,
  input  logic                         dn_stall,
  output ckbb_pkg::hit_t               dn_data
);
  import ckbb_pkg::*;

  logic v1_r, v1_nxt;
  pix_t p1_r, p1_nxt;
  logic v2_r, v2_nxt;
  hit_t h2_r, h2_nxt;
  logic stall1, stall2;

  assign stall2   = v2_r & dn_stall;
  assign stall1   = v1_r & stall2;
  assign in_stall = stall1;
  assign dn_valid = v2_r;
  assign dn_data  = h2_r;

  always_comb begin
    v1_nxt = v1_r;
    p1_nxt = p1_r;
    if (!stall1) begin
      v1_nxt       = in_valid;
      p1_nxt.x     = in_pix_x;
      p1_nxt.y     = in_pix_y;
      p1_nxt.blue  = in_blue_val;
      p1_nxt.green = in_green_val;
      p1_nxt.red   = in_red_val;
      p1_nxt.last  = in_frame_end;
    end
  end

  always_comb begin
    v2_nxt = v2_r;
    h2_nxt = h2_r;
    if (!stall2) begin
      v2_nxt      = v1_r;
      h2_nxt.x    = clamp_coord(p1_r.x, MAX_WIDTH);
      h2_nxt.y    = clamp_coord(p1_r.y, MAX_HEIGHT);
      h2_nxt.hit  = chan_ok(p1_r.blue, refs.blue, refs.tol) &&
                    chan_ok(p1_r.green, refs.green, refs.tol) &&
                    chan_ok(p1_r.red, refs.red, refs.tol);
      h2_nxt.last = p1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    h2_r <= h2_nxt;
  end

endmodule

/* rtl/ckbb_track.sv */
`include "color_key_bounding_box_top_macros.svh"

module ckbb_track (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_stall,
  input  ckbb_pkg::hit_t up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output ckbb_pkg::box_t dn_data
);
  import ckbb_pkg::*;

  logic [COORD_W-1:0] run_min_x_r, run_min_x_nxt;
  logic [COORD_W-1:0] run_min_y_r, run_min_y_nxt;
  logic [COORD_W-1:0] run_max_x_r, run_max_x_nxt;
  logic [COORD_W-1:0] run_max_y_r, run_max_y_nxt;
  logic               run_any_r, run_any_nxt;
  logic               v3_r, v3_nxt;
  box_t               b3_r, b3_nxt;
  logic               stall3, adv;
  logic [COORD_W-1:0] n_min_x, n_min_y, n_max_x, n_max_y;
  logic               n_any;

  assign stall3   = v3_r & dn_stall;
  assign up_stall = stall3;
  assign adv      = up_valid & ~stall3;
  assign dn_valid = v3_r;
  assign dn_data  = b3_r;

  always_comb begin
    n_min_x = (up_data.hit && up_data.x < run_min_x_r) ? up_data.x : run_min_x_r;
    n_max_x = (up_data.hit && up_data.x > run_max_x_r) ? up_data.x : run_max_x_r;
    n_min_y = (up_data.hit && up_data.y < run_min_y_r) ? up_data.y : run_min_y_r;
    n_max_y = (up_data.hit && up_data.y > run_max_y_r) ? up_data.y : run_max_y_r;
    n_any   = run_any_r | up_data.hit;
  end

  always_comb begin
    run_min_x_nxt = run_min_x_r;
    run_min_y_nxt = run_min_y_r;
    run_max_x_nxt = run_max_x_r;
    run_max_y_nxt = run_max_y_r;
    run_any_nxt   = run_any_r;
    b3_nxt        = b3_r;
    v3_nxt        = v3_r;
    if (!stall3) begin
      v3_nxt = up_valid;
    end
    if (adv) begin
      b3_nxt.mask  = up_data.hit;
      b3_nxt.done  = up_data.last;
      b3_nxt.found = up_data.last & n_any;
      b3_nxt.min_x = n_min_x;
      b3_nxt.min_y = n_min_y;
      b3_nxt.max_x = n_max_x;
      b3_nxt.max_y = n_max_y;
      if (up_data.last) begin
        run_min_x_nxt = '1;
        run_min_y_nxt = '1;
        run_max_x_nxt = '0;
        run_max_y_nxt = '0;
        run_any_nxt   = 1'b0;
      end else begin
        run_min_x_nxt = n_min_x;
        run_min_y_nxt = n_min_y;
        run_max_x_nxt = n_max_x;
        run_max_y_nxt = n_max_y;
        run_any_nxt   = n_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_x_r <= '1;
      run_min_y_r <= '1;
      run_max_x_r <= '0;
      run_max_y_r <= '0;
      run_any_r   <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      run_min_x_r <= run_min_x_nxt;
      run_min_y_r <= run_min_y_nxt;
      run_max_x_r <= run_max_x_nxt;
      run_max_y_r <= run_max_y_nxt;
      run_any_r   <= run_any_nxt;
      v3_r        <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b3_r <= b3_nxt;
  end

  `CKBB_ASSERT_NEXT(a_clear_after_last, adv && up_data.last,
    !run_any_r && run_min_x_r == '1 && run_max_y_r == '0, "box not cleared after frame end")
  `CKBB_ASSERT_SAME(a_empty_box_reset, !run_any_r,
    run_min_x_r == '1 && run_min_y_r == '1 && run_max_x_r == '0 && run_max_y_r == '0,
    "running box changed without a hit")
  `CKBB_ASSERT_SAME(a_found_ordered, v3_r && b3_r.found,
    b3_r.done && b3_r.min_x <= b3_r.max_x && b3_r.min_y <= b3_r.max_y,
    "reported box is not ordered")

endmodule

/* rtl/ckbb_report.sv */
module ckbb_report (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_stall,
  input  ckbb_pkg::box_t               up_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_mask_bit,
  output logic                         out_frame_done,
  output logic                         out_found,
  output logic [ckbb_pkg::COORD_W-1:0] out_box_min_x,
  output logic [ckbb_pkg::COORD_W-1:0] out_box_min_y,
  output logic [ckbb_pkg::COORD_W-1:0] out_box_max_x,
  output logic [ckbb_pkg::COORD_W-1:0] out_box_max_y,
  output logic [ckbb_pkg::COORD_W-1:0] out_center_x,
  output logic [ckbb_pkg::COORD_W-1:0] out_center_y,
  output logic [ckbb_pkg::ARM_W-1:0]   out_arm_len
);
  import ckbb_pkg::*;

  logic               v4_r, v4_nxt;
  box_t               box_r, box_nxt;
  logic [COORD_W-1:0] cx_r, cx_nxt;
  logic [COORD_W-1:0] cy_r, cy_nxt;
  logic [ARM_W-1:0]   arm_r, arm_nxt;
  logic               stall4;
  logic [COORD_W-1:0] dx, dy, sm;

  assign stall4   = v4_r & out_stall;
  assign up_stall = stall4;

  always_comb begin
    dx = up_data.max_x - up_data.min_x;
    dy = up_data.max_y - up_data.min_y;
    sm = (dx < dy) ? dx : dy;
  end

  always_comb begin
    v4_nxt  = v4_r;
    box_nxt = box_r;
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    arm_nxt = arm_r;
    if (!stall4) begin
      v4_nxt       = up_valid;
      box_nxt      = '0;
      box_nxt.mask = up_data.mask;
      box_nxt.done = up_data.done;
      cx_nxt       = '0;
      cy_nxt       = '0;
      arm_nxt      = '0;
      if (up_data.found) begin
        box_nxt = up_data;
        cx_nxt  = up_data.max_x - (dx >> 1);
        cy_nxt  = up_data.max_y - (dy >> 1);
        arm_nxt = arm_of(sm);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    box_r <= box_nxt;
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    arm_r <= arm_nxt;
  end

  assign out_valid      = v4_r;
  assign out_mask_bit   = box_r.mask;
  assign out_frame_done = box_r.done;
  assign out_found      = box_r.found;
  assign out_box_min_x  = box_r.min_x;
  assign out_box_min_y  = box_r.min_y;
  assign out_box_max_x  = box_r.max_x;
  assign out_box_max_y  = box_r.max_y;
  assign out_center_x   = cx_r;
  assign out_center_y   = cy_r;
  assign out_arm_len    = arm_r;

endmodule

/* rtl/color_key_bounding_box_top.sv */
// Channel   Direction  Handshake            Contents
// in_       input      in_valid/in_stall    pixel column, row, B, G, R, end of frame
// out_      output     out_valid/out_stall  hit bit, frame done, box, center, arm length
// cfg_      input      cfg_valid/cfg_ready  register index and 8-bit write data
//
// One pixel transaction is accepted every cycle while in_stall is low.
// The four register stages each hold one transaction and advance on their own when the
// next stage is free, so a stalled output blocks the input only once the pipe is full.
// Reset loads the reference color and tolerance defaults and empties the running box.
// Configuration writes are always ready and take effect on the next cycle.
module color_key_bounding_box_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ckbb_pkg::COORD_W-1:0] in_pix_x,
  input  logic [ckbb_pkg::COORD_W-1:0] in_pix_y,
  input  logic [ckbb_pkg::CHAN_W-1:0]  in_blue_val,
  input  logic [ckbb_pkg::CHAN_W-1:0]  in_green_val,
  input  logic [ckbb_pkg::CHAN_W-1:0]  in_red_val,
  input  logic                         in_frame_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_mask_bit,
  output logic                         out_frame_done,
  output logic                         out_found,
  output logic [ckbb_pkg::COORD_W-1:0] out_box_min_x,
  output logic [ckbb_pkg::COORD_W-1:0] out_box_min_y,
  output logic [ckbb_pkg::COORD_W-1:0] out_box_max_x,
  output logic [ckbb_pkg::COORD_W-1:0] out_box_max_y,
  output logic [ckbb_pkg::COORD_W-1:0] out_center_x,
  output logic [ckbb_pkg::COORD_W-1:0] out_center_y,
  output logic [ckbb_pkg::ARM_W-1:0]   out_arm_len,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ckbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ckbb_pkg::CHAN_W-1:0]  cfg_data
);
  import ckbb_pkg::*;

  color_ref_t refs_r, refs_nxt;
  logic       h_valid, h_stall;
  hit_t       h_data;
  logic       b_valid, b_stall;
  box_t       b_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    refs_nxt = refs_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RED:   refs_nxt.red   = cfg_data;
        REG_GREEN: refs_nxt.green = cfg_data;
        REG_BLUE:  refs_nxt.blue  = cfg_data;
        REG_TOL:   refs_nxt.tol   = cfg_data;
        default:   refs_nxt = refs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refs_r.red   <= RST_RED;
      refs_r.green <= RST_GREEN;
      refs_r.blue  <= RST_BLUE;
      refs_r.tol   <= RST_TOL;
    end else begin
      refs_r <= refs_nxt;
    end
  end

  ckbb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pix_x     (in_pix_x),
    .in_pix_y     (in_pix_y),
    .in_blue_val  (in_blue_val),
    .in_green_val (in_green_val),
    .in_red_val   (in_red_val),
    .in_frame_end (in_frame_end),
    .refs         (refs_r),
    .dn_valid     (h_valid),
    .dn_stall     (h_stall),
    .dn_data      (h_data)
  );

  ckbb_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (h_valid),
    .up_stall (h_stall),
    .up_data  (h_data),
    .dn_valid (b_valid),
    .dn_stall (b_stall),
    .dn_data  (b_data)
  );

  ckbb_report u_report (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (b_valid),
    .up_stall       (b_stall),
    .up_data        (b_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mask_bit   (out_mask_bit),
    .out_frame_done (out_frame_done),
    .out_found      (out_found),
    .out_box_min_x  (out_box_min_x),
    .out_box_min_y  (out_box_min_y),
    .out_box_max_x  (out_box_max_x),
    .out_box_max_y  (out_box_max_y),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y),
    .out_arm_len    (out_arm_len)
  );

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import ckbb_pkg::*;

  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic               mask;
    logic               done;
    logic               found;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
    logic [COORD_W-1:0] ctr_x;
    logic [COORD_W-1:0] ctr_y;
    logic [ARM_W-1:0]   arm;
  } pixel_result_t;

  class bbox_scoreboard;
    logic [CHAN_W-1:0]  ref_r;
    logic [CHAN_W-1:0]  ref_g;
    logic [CHAN_W-1:0]  ref_b;
    logic [CHAN_W-1:0]  tol;
    logic [COORD_W-1:0] lo_x;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W-1:0] hi_x;
    logic [COORD_W-1:0] hi_y;
    bit                 seen_hit;
    pixel_result_t      predicted[$];
    int                 errors;

    function new();
      ref_r  = RST_RED;
      ref_g  = RST_GREEN;
      ref_b  = RST_BLUE;
      tol    = RST_TOL;
      errors = 0;
      clear_box();
    endfunction

    function void clear_box();
      lo_x     = '1;
      lo_y     = '1;
      hi_x     = '0;
      hi_y     = '0;
      seen_hit = 1'b0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CHAN_W-1:0] d);
      case (idx)
        REG_RED:   ref_r = d;
        REG_GREEN: ref_g = d;
        REG_BLUE:  ref_b = d;
        REG_TOL:   tol = d;
        default: ;
      endcase
    endfunction

    function bit in_band(logic [CHAN_W-1:0] v, logic [CHAN_W-1:0] r);
      int vi;
      int ri;
      int ti;
      vi = int'(v);
      ri = int'(r);
      ti = int'(tol);
      return (vi <= ri + ti) && (vi + ti >= ri);
    endfunction

    function logic [COORD_W-1:0] limit_coord(logic [COORD_W-1:0] v, int lim);
      if (int'(v) >= lim) begin
        return COORD_W'(lim - 1);
      end
      return v;
    endfunction

    function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] r, logic last);
      pixel_result_t      res;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic [COORD_W-1:0] sm;
      int                 arm;
      res = '0;
      cx = limit_coord(x, MAX_WIDTH);
      cy = limit_coord(y, MAX_HEIGHT);
      res.mask = in_band(b, ref_b) && in_band(g, ref_g) && in_band(r, ref_r);
      if (res.mask) begin
        if (cx < lo_x) lo_x = cx;
        if (cx > hi_x) hi_x = cx;
        if (cy < lo_y) lo_y = cy;
        if (cy > hi_y) hi_y = cy;
        seen_hit = 1'b1;
      end
      if (last) begin
        res.done = 1'b1;
        if (seen_hit) begin
          dx = hi_x - lo_x;
          dy = hi_y - lo_y;
          sm = (dx < dy) ? dx : dy;
          arm = int'(sm) * 3 / 10;
          if (arm > ARM_CAP) arm = ARM_CAP;
          res.found = 1'b1;
          res.min_x = lo_x;
          res.min_y = lo_y;
          res.max_x = hi_x;
          res.max_y = hi_y;
          res.ctr_x = hi_x - dx / 2;
          res.ctr_y = hi_y - dy / 2;
          res.arm   = ARM_W'(arm);
        end
        clear_box();
      end
      predicted.push_back(res);
    endfunction

    function void check_field(string field, logic [COORD_W-1:0] want,
                              logic [COORD_W-1:0] got);
      if (got !== want) begin
        $display("%0t %s: expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (predicted.size() == 0) begin
        $display("%0t result transaction with no pixel outstanding", $time);
        errors++;
        return;
      end
      want = predicted.pop_front();
      check_field("mask_bit", COORD_W'(want.mask), COORD_W'(got.mask));
      check_field("frame_done", COORD_W'(want.done), COORD_W'(got.done));
      check_field("found", COORD_W'(want.found), COORD_W'(got.found));
      check_field("box_min_x", want.min_x, got.min_x);
      check_field("box_min_y", want.min_y, got.min_y);
      check_field("box_max_x", want.max_x, got.max_x);
      check_field("box_max_y", want.max_y, got.max_y);
      check_field("center_x", want.ctr_x, got.ctr_x);
      check_field("center_y", want.ctr_y, got.ctr_y);
      check_field("arm_len", COORD_W'(want.arm), COORD_W'(got.arm));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [COORD_W-1:0]   in_pix_x;
  logic [COORD_W-1:0]   in_pix_y;
  logic [CHAN_W-1:0]    in_blue_val;
  logic [CHAN_W-1:0]    in_green_val;
  logic [CHAN_W-1:0]    in_red_val;
  logic                 in_frame_end;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_mask_bit;
  logic                 out_frame_done;
  logic                 out_found;
  logic [COORD_W-1:0]   out_box_min_x;
  logic [COORD_W-1:0]   out_box_min_y;
  logic [COORD_W-1:0]   out_box_max_x;
  logic [COORD_W-1:0]   out_box_max_y;
  logic [COORD_W-1:0]   out_center_x;
  logic [COORD_W-1:0]   out_center_y;
  logic [ARM_W-1:0]     out_arm_len;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CHAN_W-1:0]    cfg_data;

  bbox_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  color_key_bounding_box_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pix_x      (in_pix_x),
    .in_pix_y      (in_pix_y),
    .in_blue_val   (in_blue_val),
    .in_green_val  (in_green_val),
    .in_red_val    (in_red_val),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mask_bit  (out_mask_bit),
    .out_frame_done(out_frame_done),
    .out_found     (out_found),
    .out_box_min_x (out_box_min_x),
    .out_box_min_y (out_box_min_y),
    .out_box_max_x (out_box_max_x),
    .out_box_max_y (out_box_max_y),
    .out_center_x  (out_center_x),
    .out_center_y  (out_center_y),
    .out_arm_len   (out_arm_len),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] r, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pix_x     <= x;
    in_pix_y     <= y;
    in_blue_val  <= b;
    in_green_val <= g;
    in_red_val   <= r;
    in_frame_end <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_pixel(x, y, b, g, r, last);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CHAN_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic write_colors(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] t);
    write_reg(REG_RED, r);
    write_reg(REG_GREEN, g);
    write_reg(REG_BLUE, b);
    write_reg(REG_TOL, t);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.predicted.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] near_level(logic [CHAN_W-1:0] lvl);
    int lo;
    int hi;
    lo = int'(lvl) - int'(sb.tol) - 2;
    hi = int'(lvl) + int'(sb.tol) + 2;
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    return CHAN_W'($urandom_range(hi, lo));
  endfunction

  task automatic run_directed();
    send_pixel(0, 0, 15, 255, 175, 1'b0);
    send_pixel(2047, 2047, 115, 175, 255, 1'b0);
    send_pixel(100, 100, 14, 225, 225, 1'b0);
    send_pixel(100, 100, 116, 225, 225, 1'b0);
    send_pixel(5, 5, 65, 174, 225, 1'b0);
    send_pixel(5, 5, 65, 225, 174, 1'b0);
    send_pixel(1024, 1024, 0, 0, 0, 1'b1);
    send_pixel(7, 9, 255, 0, 255, 1'b0);
    send_pixel(3, 3, 0, 255, 0, 1'b1);
    send_pixel(2047, 0, 65, 225, 225, 1'b1);
    send_pixel(10, 20, 65, 225, 225, 1'b0);
    send_pixel(15, 30, 65, 225, 225, 1'b0);
    send_pixel(27, 25, 65, 225, 225, 1'b1);
    send_pixel(0, 0, 65, 225, 225, 1'b0);
    send_pixel(14, 16, 65, 225, 225, 1'b1);
    send_pixel(0, 0, 65, 225, 225, 1'b0);
    send_pixel(40, 60, 65, 225, 225, 1'b1);
    wait_drain();
    write_colors(0, 0, 0, 0);
    send_pixel(1, 2, 0, 0, 0, 1'b0);
    send_pixel(3, 4, 1, 0, 0, 1'b1);
    wait_drain();
    write_colors(255, 255, 255, 0);
    send_pixel(2046, 2046, 255, 255, 255, 1'b1);
    wait_drain();
    write_colors(128, 128, 128, 255);
    send_pixel(0, 2047, 0, 255, 0, 1'b1);
    wait_drain();
  endtask

  task automatic run_frames(input int n_items);
    int                 sent;
    int                 len;
    int                 span;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [CHAN_W-1:0]  b;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  r;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(30, 1);
      span = ($urandom_range(3) == 0) ? 2047 : $urandom_range(40, 0);
      bx = COORD_W'($urandom_range(2047 - span, 0));
      by = COORD_W'($urandom_range(2047 - span, 0));
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < 65) begin
          b = near_level(sb.ref_b);
          g = near_level(sb.ref_g);
          r = near_level(sb.ref_r);
        end else begin
          b = CHAN_W'($urandom);
          g = CHAN_W'($urandom);
          r = CHAN_W'($urandom);
        end
        send_pixel(bx + COORD_W'($urandom_range(span, 0)),
                   by + COORD_W'($urandom_range(span, 0)),
                   b, g, r, k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    pixel_result_t got;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
        got.mask  = out_mask_bit;
        got.done  = out_frame_done;
        got.found = out_found;
        got.min_x = out_box_min_x;
        got.min_y = out_box_min_y;
        got.max_x = out_box_max_x;
        got.max_y = out_box_max_y;
        got.ctr_x = out_center_x;
        got.ctr_y = out_center_y;
        got.arm   = out_arm_len;
        sb.check_result(got);
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
          quiet = 0;
        end else begin
          quiet++;
        end
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    sb = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_pix_x     <= '0;
    in_pix_y     <= '0;
    in_blue_val  <= '0;
    in_green_val <= '0;
    in_red_val   <= '0;
    in_frame_end <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_RED;
    cfg_data     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int p = 0; p < 9; p++) begin
      case (p)
        1: write_colors(0, 0, 0, 0);
        2: write_colors(255, 255, 255, 0);
        4: write_colors(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), 255);
        7: write_colors(255, 0, 255, 3);
        default: write_colors(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                              CHAN_W'($urandom_range(90, 0)));
      endcase
      if (p < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 47;
      end else if (p < 6) begin
        send_idle_pct = 47;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // A long output hold lets the pipe fill so that the input stalls.
      if (p % 3 == 0) hold_cycles = 80;
      run_frames(155);
      wait_drain();
    end
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
